// File: sv/ctfe_pkg.sv
`default_nettype none
package ctfe_pkg;

  // operation codes carried on the input channel
  typedef enum logic [2:0] {
    OP_MODE = 3'd0,
    OP_NEXT = 3'd1,
    OP_INC  = 3'd2,
    OP_DEC  = 3'd3,
    OP_TICK = 3'd4,
    OP_LOAD = 3'd5,
    OP_RSV6 = 3'd6,
    OP_RSV7 = 3'd7
  } op_t;

  // field select codes
  localparam logic [2:0] FLD_YEAR   = 3'd0;
  localparam logic [2:0] FLD_MONTH  = 3'd1;
  localparam logic [2:0] FLD_DAY    = 3'd2;
  localparam logic [2:0] FLD_HOUR   = 3'd3;
  localparam logic [2:0] FLD_MINUTE = 3'd4;
  localparam logic [2:0] FLD_SECOND = 3'd5;

  // field limits
  localparam logic [6:0] YEAR_MAX   = 7'd99;
  localparam logic [3:0] MONTH_MAX  = 4'd12;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;
  localparam logic [15:0] BLINK_TICKS_RST = 16'd500;

  // one result item
  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       editing;
    logic [2:0] selected_field;
    logic       blank_selected;
    logic       commit;
  } res_t;

  // month length, february by the every-fourth-year rule
  function automatic logic [4:0] days_in(input logic [6:0] yr, input logic [3:0] mo);
    logic [4:0] len;
    begin
      case (mo)
        4'd2:                          len = (yr[1:0] == 2'd0) ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:       len = 5'd30;
        default:                       len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage
`default_nettype wire

// File: sv/calendar_time_field_editor_unit.sv
// Calendar time editor: holds year (two digits), month, day, hour, minute and
// second plus an edit mode, a selected field and a blink phase. Every input
// transfer yields exactly one result showing the state after the update; one
// item is taken per clock while input ready is high, the update being a single
// registered pass. The result register is backed by one skid slot, so input
// ready only drops when two results are waiting. blink_ticks is written through
// the cfg port, which is always ready; write it only while the block is idle.
`default_nettype none
module calendar_time_field_editor_unit import ctfe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_operation,
  input  wire logic [6:0]  in_load_year,
  input  wire logic [3:0]  in_load_month,
  input  wire logic [4:0]  in_load_day,
  input  wire logic [4:0]  in_load_hour,
  input  wire logic [5:0]  in_load_minute,
  input  wire logic [5:0]  in_load_second,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       out_year_out,
  output logic [3:0]       out_month_out,
  output logic [4:0]       out_day_out,
  output logic [4:0]       out_hour_out,
  output logic [5:0]       out_minute_out,
  output logic [5:0]       out_second_out,
  output logic             out_editing,
  output logic [2:0]       out_selected_field,
  output logic             out_blank_selected,
  output logic             out_commit,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_blink_ticks
);

  logic [15:0] blink_ticks_r;
  logic [6:0]  year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [5:0]  second_r, second_nxt;
  logic        edit_r, edit_nxt;
  logic [2:0]  sel_r, sel_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic        phase_r, phase_nxt;
  logic        commit_nxt;

  logic        out_valid_r, skid_valid_r;
  res_t        out_r, skid_r, res_nxt;

  logic        in_xfer;
  logic        step;
  logic        up;
  logic [5:0]  day_step;
  logic [4:0]  len;
  logic [16:0] tick_sum;
  op_t         op;

  assign op        = op_t'(in_operation);
  assign in_ready  = !skid_valid_r;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_ticks_r <= BLINK_TICKS_RST;
    end else if (cfg_valid) begin
      blink_ticks_r <= cfg_blink_ticks;
    end
  end

  // field step and day fix-up
  always_comb begin
    step       = edit_r && (op == OP_INC || op == OP_DEC);
    up         = (op == OP_INC);
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_step   = {1'b0, day_r};
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    len        = days_in(year_r, month_r);
    day_nxt    = day_r;
    if (step) begin
      case (sel_r)
        FLD_YEAR: begin
          if (up) year_nxt = (year_r >= YEAR_MAX) ? 7'd0 : year_r + 7'd1;
          else    year_nxt = (year_r == 7'd0) ? YEAR_MAX : year_r - 7'd1;
        end
        FLD_MONTH: begin
          if (up) month_nxt = (month_r >= MONTH_MAX) ? 4'd1 : month_r + 4'd1;
          else    month_nxt = (month_r <= 4'd1) ? MONTH_MAX : month_r - 4'd1;
        end
        FLD_HOUR: begin
          if (up) hour_nxt = (hour_r >= HOUR_MAX) ? 5'd0 : hour_r + 5'd1;
          else    hour_nxt = (hour_r == 5'd0) ? HOUR_MAX : hour_r - 5'd1;
        end
        FLD_MINUTE: begin
          if (up) minute_nxt = (minute_r >= MINSEC_MAX) ? 6'd0 : minute_r + 6'd1;
          else    minute_nxt = (minute_r == 6'd0) ? MINSEC_MAX : minute_r - 6'd1;
        end
        FLD_SECOND: begin
          if (up) second_nxt = (second_r >= MINSEC_MAX) ? 6'd0 : second_r + 6'd1;
          else    second_nxt = (second_r == 6'd0) ? MINSEC_MAX : second_r - 6'd1;
        end
        default: ;
      endcase
      len = days_in(year_nxt, month_nxt);
      // day steps against the new month length
      if (sel_r == FLD_DAY) begin
        if (up) day_step = {1'b0, day_r} + 6'd1;
        else    day_step = (day_r <= 5'd1) ? {1'b0, len} : {1'b0, day_r} - 6'd1;
      end
      day_nxt = (day_step > {1'b0, len}) ? 5'd1 : day_step[4:0];
    end
  end

  // mode, selection, blink and load
  always_comb begin
    edit_nxt   = edit_r;
    sel_nxt    = sel_r;
    tick_nxt   = tick_r;
    phase_nxt  = phase_r;
    commit_nxt = 1'b0;
    tick_sum   = {1'b0, tick_r} + 17'd1;
    res_nxt    = '0;
    case (op)
      OP_MODE: begin
        edit_nxt   = !edit_r;
        commit_nxt = edit_r;
      end
      OP_NEXT: begin
        if (edit_r) sel_nxt = (sel_r >= FLD_SECOND) ? FLD_YEAR : sel_r + 3'd1;
      end
      OP_TICK: begin
        if (tick_sum >= {1'b0, blink_ticks_r}) begin
          tick_nxt  = '0;
          phase_nxt = !phase_r;
        end else begin
          tick_nxt = tick_sum[15:0];
        end
      end
      default: ;
    endcase
    res_nxt.year   = year_nxt;
    res_nxt.month  = month_nxt;
    res_nxt.day    = day_nxt;
    res_nxt.hour   = hour_nxt;
    res_nxt.minute = minute_nxt;
    res_nxt.second = second_nxt;
    if (op == OP_LOAD && !edit_r) begin
      res_nxt.year   = (in_load_year > YEAR_MAX) ? 7'd0 : in_load_year;
      res_nxt.month  = (in_load_month == 4'd0 || in_load_month > MONTH_MAX)
                       ? 4'd1 : in_load_month;
      res_nxt.day    = (in_load_day == 5'd0) ? 5'd1 : in_load_day;
      res_nxt.hour   = (in_load_hour > HOUR_MAX) ? 5'd0 : in_load_hour;
      res_nxt.minute = (in_load_minute > MINSEC_MAX) ? 6'd0 : in_load_minute;
      res_nxt.second = (in_load_second > MINSEC_MAX) ? 6'd0 : in_load_second;
    end
    res_nxt.editing        = edit_nxt;
    res_nxt.selected_field = sel_nxt;
    res_nxt.blank_selected = edit_nxt && phase_nxt;
    res_nxt.commit         = commit_nxt;
  end

  // state update on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r   <= '0;
      month_r  <= 4'd1;
      day_r    <= 5'd1;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
      edit_r   <= 1'b0;
      sel_r    <= FLD_YEAR;
      tick_r   <= '0;
      phase_r  <= 1'b0;
    end else if (in_xfer) begin
      year_r   <= res_nxt.year;
      month_r  <= res_nxt.month;
      day_r    <= res_nxt.day;
      hour_r   <= res_nxt.hour;
      minute_r <= res_nxt.minute;
      second_r <= res_nxt.second;
      edit_r   <= edit_nxt;
      sel_r    <= sel_nxt;
      tick_r   <= tick_nxt;
      phase_r  <= phase_nxt;
    end
  end

  // result register with one skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) out_r <= skid_r;
      else if (in_xfer) out_r <= res_nxt;
    end else if (in_xfer) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_year_out       = out_r.year;
  assign out_month_out      = out_r.month;
  assign out_day_out        = out_r.day;
  assign out_hour_out       = out_r.hour;
  assign out_minute_out     = out_r.minute;
  assign out_second_out     = out_r.second;
  assign out_editing        = out_r.editing;
  assign out_selected_field = out_r.selected_field;
  assign out_blank_selected = out_r.blank_selected;
  assign out_commit         = out_r.commit;

  // skid slot only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot holds a result with the output register empty");

  // a commit always leaves edit mode
  a_commit_show: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.commit) |-> !out_r.editing)
    else $error("commit reported while still editing");

  // month register stays in calendar range
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (month_r >= 4'd1 && month_r <= MONTH_MAX))
    else $error("month register out of range");

  // selection stays on one of the six fields
  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (sel_r <= FLD_SECOND))
    else $error("field selection out of range");

endmodule
`default_nettype wire

// File: tb/tb_calendar_time_field_editor_unit.sv
module tb_calendar_time_field_editor_unit;
  import ctfe_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 254;
  localparam int SETTLE_CYCLES = 10;

  // shadow copy of the editor state, with the display values still owed by the block
  class calendar_shadow;
    logic [15:0] blink_ticks;
    int year_r, month_r, day_r, hour_r, minute_r, second_r;
    bit edit_mode;
    int field_sel;
    int tick_count;
    bit blink_phase;
    res_t display_queue[$];
    int mismatches;

    function new();
      blink_ticks = BLINK_TICKS_RST;
      year_r = 0;
      month_r = 1;
      day_r = 1;
      hour_r = 0;
      minute_r = 0;
      second_r = 0;
      edit_mode = 1'b0;
      field_sel = 0;
      tick_count = 0;
      blink_phase = 1'b0;
      mismatches = 0;
    endfunction

    // february is long in every year divisible by four, 00 included
    function int month_days(int yr, int mo);
      if (mo == 2) return (yr % 4 == 0) ? 29 : 28;
      if (mo == 4 || mo == 6 || mo == 9 || mo == 11) return 30;
      return 31;
    endfunction

    // step the selected field, then pull every field back into range
    function void step_field(int delta);
      int t[6];
      int len;
      t[0] = year_r;
      t[1] = month_r;
      t[2] = day_r;
      t[3] = hour_r;
      t[4] = minute_r;
      t[5] = second_r;
      t[field_sel] += delta;
      if (delta > 0) begin
        if (t[0] > int'(YEAR_MAX)) t[0] = 0;
        if (t[1] > int'(MONTH_MAX)) t[1] = 1;
        len = month_days(t[0], t[1]);
        if (t[2] > len) t[2] = 1;
        if (t[3] > int'(HOUR_MAX)) t[3] = 0;
        if (t[4] > int'(MINSEC_MAX)) t[4] = 0;
        if (t[5] > int'(MINSEC_MAX)) t[5] = 0;
      end else begin
        if (t[0] < 0) t[0] = int'(YEAR_MAX);
        if (t[1] < 1) t[1] = int'(MONTH_MAX);
        len = month_days(t[0], t[1]);
        if (t[2] < 1) t[2] = len;
        if (t[2] > len) t[2] = 1;
        if (t[3] < 0) t[3] = int'(HOUR_MAX);
        if (t[4] < 0) t[4] = int'(MINSEC_MAX);
        if (t[5] < 0) t[5] = int'(MINSEC_MAX);
      end
      year_r = t[0];
      month_r = t[1];
      day_r = t[2];
      hour_r = t[3];
      minute_r = t[4];
      second_r = t[5];
    endfunction

    // apply one accepted key and queue the display it should produce
    function void apply_key(op_t op, logic [6:0] ly, logic [3:0] lmo, logic [4:0] ld,
                            logic [4:0] lh, logic [5:0] lmi, logic [5:0] ls);
      bit commit;
      res_t r;
      commit = 1'b0;
      case (op)
        OP_MODE: begin
          commit = edit_mode;
          edit_mode = !edit_mode;
        end
        OP_NEXT: begin
          if (edit_mode) field_sel = (field_sel + 1) % 6;
        end
        OP_INC: begin
          if (edit_mode) step_field(1);
        end
        OP_DEC: begin
          if (edit_mode) step_field(-1);
        end
        OP_TICK: begin
          tick_count++;
          if (tick_count >= int'(blink_ticks)) begin
            tick_count = 0;
            blink_phase = !blink_phase;
          end
        end
        OP_LOAD: begin
          if (!edit_mode) begin
            year_r = (ly > YEAR_MAX) ? 0 : int'(ly);
            month_r = (lmo == 0 || lmo > MONTH_MAX) ? 1 : int'(lmo);
            day_r = (ld == 0) ? 1 : int'(ld);
            hour_r = (lh > HOUR_MAX) ? 0 : int'(lh);
            minute_r = (lmi > MINSEC_MAX) ? 0 : int'(lmi);
            second_r = (ls > MINSEC_MAX) ? 0 : int'(ls);
          end
        end
        default: ;
      endcase
      r.year = year_r[6:0];
      r.month = month_r[3:0];
      r.day = day_r[4:0];
      r.hour = hour_r[4:0];
      r.minute = minute_r[5:0];
      r.second = second_r[5:0];
      r.editing = edit_mode;
      r.selected_field = field_sel[2:0];
      r.blank_selected = edit_mode & blink_phase;
      r.commit = commit;
      display_queue.push_back(r);
    endfunction

    function void note_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // compare one display transfer with the oldest one owed
    function void compare_display(res_t got);
      res_t want;
      if (display_queue.size() == 0) begin
        $display("%0t: display transfer with nothing owed, got %h", $time, got);
        mismatches++;
        return;
      end
      want = display_queue.pop_front();
      note_field("year", 8'(want.year), 8'(got.year));
      note_field("month", 8'(want.month), 8'(got.month));
      note_field("day", 8'(want.day), 8'(got.day));
      note_field("hour", 8'(want.hour), 8'(got.hour));
      note_field("minute", 8'(want.minute), 8'(got.minute));
      note_field("second", 8'(want.second), 8'(got.second));
      note_field("editing", 8'(want.editing), 8'(got.editing));
      note_field("selected_field", 8'(want.selected_field), 8'(got.selected_field));
      note_field("blank_selected", 8'(want.blank_selected), 8'(got.blank_selected));
      note_field("commit", 8'(want.commit), 8'(got.commit));
    endfunction

    function int owed();
      return display_queue.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [2:0] in_operation;
  logic [6:0] in_load_year;
  logic [3:0] in_load_month;
  logic [4:0] in_load_day;
  logic [4:0] in_load_hour;
  logic [5:0] in_load_minute;
  logic [5:0] in_load_second;
  logic out_valid;
  logic out_ready;
  logic [6:0] out_year_out;
  logic [3:0] out_month_out;
  logic [4:0] out_day_out;
  logic [4:0] out_hour_out;
  logic [5:0] out_minute_out;
  logic [5:0] out_second_out;
  logic out_editing;
  logic [2:0] out_selected_field;
  logic out_blank_selected;
  logic out_commit;
  logic cfg_valid;
  logic cfg_ready;
  logic [15:0] cfg_blink_ticks;

  calendar_shadow board;
  bit tx_calm;
  bit rx_calm;
  int idle_cycles = 0;

  calendar_time_field_editor_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_load_year(in_load_year),
    .in_load_month(in_load_month),
    .in_load_day(in_load_day),
    .in_load_hour(in_load_hour),
    .in_load_minute(in_load_minute),
    .in_load_second(in_load_second),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_year_out(out_year_out),
    .out_month_out(out_month_out),
    .out_day_out(out_day_out),
    .out_hour_out(out_hour_out),
    .out_minute_out(out_minute_out),
    .out_second_out(out_second_out),
    .out_editing(out_editing),
    .out_selected_field(out_selected_field),
    .out_blank_selected(out_blank_selected),
    .out_commit(out_commit),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_blink_ticks(cfg_blink_ticks)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // hold off until the block has delivered every display owed
  task automatic drain_results();
    do @(negedge clk); while (board.owed() != 0);
    @(posedge clk);
  endtask

  // one input transfer, with a random gap or an occasional full drain first
  task automatic send_item(op_t op, logic [6:0] ly, logic [3:0] lmo, logic [4:0] ld,
                           logic [4:0] lh, logic [5:0] lmi, logic [5:0] ls);
    int gap;
    gap = pick_gap(tx_calm);
    if ($urandom_range(0, 199) == 0) begin
      in_valid <= 1'b0;
      drain_results();
    end else if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_load_year <= ly;
    in_load_month <= lmo;
    in_load_day <= ld;
    in_load_hour <= lh;
    in_load_minute <= lmi;
    in_load_second <= ls;
    do @(posedge clk); while (!in_ready);
  endtask

  // blink period write, only with the block idle
  task automatic write_blink(logic [15:0] value);
    in_valid <= 1'b0;
    drain_results();
    cfg_valid <= 1'b1;
    cfg_blink_ticks <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // a run of random keys
  task automatic run_random(int target);
    int sent;
    int r;
    op_t op;
    logic [6:0] ly;
    logic [3:0] lmo;
    logic [4:0] ld;
    logic [4:0] lh;
    logic [5:0] lmi;
    logic [5:0] ls;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 7) op = OP_MODE;
      else if (r < 22) op = OP_NEXT;
      else if (r < 45) op = OP_INC;
      else if (r < 68) op = OP_DEC;
      else if (r < 86) op = OP_TICK;
      else if (r < 96) op = OP_LOAD;
      else op = ($urandom_range(0, 1) == 1) ? OP_RSV6 : OP_RSV7;
      // mostly a sane clock time, sometimes raw bits
      if ($urandom_range(0, 4) == 0) begin
        ly = 7'($urandom);
        lmo = 4'($urandom);
        ld = 5'($urandom);
        lh = 5'($urandom);
        lmi = 6'($urandom);
        ls = 6'($urandom);
      end else begin
        ly = 7'($urandom_range(0, YEAR_MAX));
        lmo = 4'($urandom_range(1, MONTH_MAX));
        ld = 5'($urandom_range(1, 31));
        lh = 5'($urandom_range(0, HOUR_MAX));
        lmi = 6'($urandom_range(0, MINSEC_MAX));
        ls = 6'($urandom_range(0, MINSEC_MAX));
      end
      send_item(op, ly, lmo, ld, lh, lmi, ls);
      sent++;
    end
  endtask

  // result side back-pressure
  initial begin : receiver
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = pick_gap(rx_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // transfer monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        board.compare_display({out_year_out, out_month_out, out_day_out, out_hour_out,
                               out_minute_out, out_second_out, out_editing,
                               out_selected_field, out_blank_selected, out_commit});
      if (in_valid && in_ready)
        board.apply_key(op_t'(in_operation), in_load_year, in_load_month, in_load_day,
                        in_load_hour, in_load_minute, in_load_second);
      if (cfg_valid && cfg_ready)
        board.blink_ticks = cfg_blink_ticks;
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("calendar_time_field_editor_unit test failed");
        $finish;
      end
    end
  end

  initial begin : main
    logic [15:0] blink_plan [6];
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_MODE;
    in_load_year = '0;
    in_load_month = '0;
    in_load_day = '0;
    in_load_hour = '0;
    in_load_minute = '0;
    in_load_second = '0;
    cfg_valid = 1'b0;
    cfg_blink_ticks = '0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // loads at the edges of the fields, out-of-range values fall back to the lowest value
    send_item(OP_LOAD, 7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    send_item(OP_LOAD, 7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
    send_item(OP_LOAD, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    // february 31 is kept until the next step
    send_item(OP_LOAD, 7'd1, 4'd2, 5'd31, 5'd0, 6'd0, 6'd0);
    // unused code and keys in show mode change nothing
    send_item(OP_RSV6, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_item(OP_NEXT, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_item(OP_MODE, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    // load while editing is dropped
    send_item(OP_LOAD, 7'd50, 4'd6, 5'd6, 5'd6, 6'd6, 6'd6);
    // year 00 is leap, so day 31 falls back to 1; then year wraps both ways
    send_item(OP_DEC, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_item(OP_DEC, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_item(OP_INC, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    // month wraps down past january
    send_item(OP_NEXT, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_item(OP_DEC, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_item(OP_DEC, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    // day wraps to the month length and back to 1
    send_item(OP_NEXT, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_item(OP_DEC, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_item(OP_INC, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    // hour and second wrap, selection wraps back to the year
    send_item(OP_NEXT, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_item(OP_DEC, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_item(OP_NEXT, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_item(OP_NEXT, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_item(OP_DEC, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_item(OP_INC, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_item(OP_NEXT, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_item(OP_TICK, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    // leaving edit mode commits
    send_item(OP_MODE, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);

    // random phases over several blink periods, extremes included
    blink_plan[0] = 16'hFFFF;
    blink_plan[1] = 16'd1;
    blink_plan[2] = 16'd0;
    blink_plan[3] = 16'($urandom_range(2, 9));
    blink_plan[4] = 16'($urandom_range(2, 9));
    blink_plan[5] = 16'($urandom_range(10, 40));
    foreach (blink_plan[i]) begin
      write_blink(blink_plan[i]);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      run_random(ITEMS_PER_PHASE);
    end

    in_valid <= 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.owed() == 0)
      $display("calendar_time_field_editor_unit test passed");
    else
      $display("calendar_time_field_editor_unit test failed");
    $finish;
  end

endmodule
